### rtl/barometric_pressure_compensation_assert.svh
// Assertion macros shared by the checker of the pressure compensation block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// Same-cycle implication, ignored while rst_n is low.
`define BPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// Next-cycle implication, ignored while rst_n is low.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

### rtl/bpc_pkg.sv
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 24;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Internal widths of the compensation chain
    localparam int DT_W    = RAW_W + 1;            // signed dT
    localparam int PROD_W  = DT_W + CAL_W + 1;     // dT times a calibration word
    localparam int TSUM_W  = TEMP_W + 1;
    localparam int OFF_W   = 37;
    localparam int SENS_W  = 36;
    localparam int SLO_W   = 18;                   // low, unsigned part of SENS
    localparam int SHI_W   = SENS_W - SLO_W;       // high, signed part of SENS
    localparam int PLO_W   = RAW_W + SLO_W;
    localparam int PHI_W   = RAW_W + 1 + SHI_W;
    localparam int FULL_W  = PHI_W + SLO_W;
    localparam int QSH_W   = 40;
    localparam int Q_W     = QSH_W + 1;
    localparam int PSUM_W  = PRES_W + 2;

    localparam logic signed [TSUM_W-1:0] TEMP_BASE = TSUM_W'(2000);
    localparam logic signed [TSUM_W-1:0] TEMP_MAX  = TSUM_W'(262143);
    localparam logic signed [TSUM_W-1:0] TEMP_MIN  = -TSUM_W'(262144);
    localparam logic signed [PSUM_W-1:0] PRES_MAX  = PSUM_W'(8388607);
    localparam logic signed [PSUM_W-1:0] PRES_MIN  = -PSUM_W'(8388608);

    // Register indexes (byte address divided by four)
    localparam logic [2:0] REG_SENS      = 3'd0;
    localparam logic [2:0] REG_OFFSET    = 3'd1;
    localparam logic [2:0] REG_SENS_TEMP = 3'd2;
    localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
    localparam logic [2:0] REG_REF_TEMP  = 3'd4;
    localparam logic [2:0] REG_SLOPE     = 3'd5;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centideg;
        logic signed [PRES_W-1:0] pressure_pa;
    } t_out_item;

endpackage

### rtl/barometric_pressure_compensation.sv
// First-order barometric compensation: each beat carries a raw pressure and a
// raw temperature conversion and yields one beat with temperature in 0.01 degC
// and pressure in Pa, both saturated. The pipeline is seven register stages
// deep and takes one beat every cycle while the output is not stalled; the wide
// SENS product is split into two partial products over two stages. An output
// stall freezes the whole pipeline. The six calibration words sit at byte
// addresses 0x00..0x14; the user must write them only while the pipeline is
// empty, and the block itself does not enforce this.
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic             cfg_wr;
    logic             advance;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_SENS:      r_c1 <= pwdata[CAL_W-1:0];
                REG_OFFSET:    r_c2 <= pwdata[CAL_W-1:0];
                REG_SENS_TEMP: r_c3 <= pwdata[CAL_W-1:0];
                REG_OFF_TEMP:  r_c4 <= pwdata[CAL_W-1:0];
                REG_REF_TEMP:  r_c5 <= pwdata[CAL_W-1:0];
                REG_SLOPE:     r_c6 <= pwdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_SENS:      prdata = {{(DATA_W-CAL_W){1'b0}}, r_c1};
            REG_OFFSET:    prdata = {{(DATA_W-CAL_W){1'b0}}, r_c2};
            REG_SENS_TEMP: prdata = {{(DATA_W-CAL_W){1'b0}}, r_c3};
            REG_OFF_TEMP:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_c4};
            REG_REF_TEMP:  prdata = {{(DATA_W-CAL_W){1'b0}}, r_c5};
            REG_SLOPE:     prdata = {{(DATA_W-CAL_W){1'b0}}, r_c6};
            default:       prdata = '0;
        endcase
    end

    // The pipeline moves as one unless the output beat is held
    logic [6:0] r_vld;
    assign advance    = !(r_vld[6] && i_out_stall);
    assign o_in_stall = !advance;
    assign o_out_valid = r_vld[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[5:0], i_in_valid};
        end
    end

    // Stage 1: dT
    logic signed [DT_W-1:0] n1_dt, r1_dt;
    logic [RAW_W-1:0]       r1_d1;
    assign n1_dt = $signed({1'b0, i_in_data.raw_temperature})
                 - $signed({1'b0, r_c5, 8'h00});

    // Stage 2: the three dT products
    logic signed [PROD_W-1:0] r2_pt, r2_po, r2_ps;
    logic [RAW_W-1:0]         r2_d1;

    // Stage 3: TEMP, OFF, SENS
    logic signed [PROD_W-1:0] pt_sh, po_sh, ps_sh;
    logic signed [TSUM_W-1:0] n3_tsum;
    logic signed [TEMP_W-1:0] n3_temp, r3_temp;
    logic signed [OFF_W-1:0]  n3_off, r3_off;
    logic signed [SENS_W-1:0] n3_sens, r3_sens;
    logic [RAW_W-1:0]         r3_d1;

    assign pt_sh   = r2_pt >>> 23;
    assign po_sh   = r2_po >>> 6;
    assign ps_sh   = r2_ps >>> 7;
    assign n3_tsum = pt_sh[TSUM_W-1:0] + TEMP_BASE;
    assign n3_off  = $signed({4'b0, r_c2, 17'b0}) + po_sh[OFF_W-1:0];
    assign n3_sens = $signed({4'b0, r_c1, 16'b0}) + ps_sh[SENS_W-1:0];

    always_comb begin
        if (n3_tsum > TEMP_MAX) begin
            n3_temp = TEMP_MAX[TEMP_W-1:0];
        end else if (n3_tsum < TEMP_MIN) begin
            n3_temp = TEMP_MIN[TEMP_W-1:0];
        end else begin
            n3_temp = n3_tsum[TEMP_W-1:0];
        end
    end

    // Stage 4: D1 times SENS as two partial products
    logic [PLO_W-1:0]         r4_plo;
    logic signed [PHI_W-1:0]  r4_phi;
    logic signed [OFF_W-1:0]  r4_off;
    logic signed [TEMP_W-1:0] r4_temp;

    // Stage 5: recombine
    logic signed [FULL_W-1:0] n5_full, r5_full;
    logic signed [OFF_W-1:0]  r5_off;
    logic signed [TEMP_W-1:0] r5_temp;
    assign n5_full = $signed({r4_phi, {SLO_W{1'b0}}})
                   + $signed({{(FULL_W-PLO_W){1'b0}}, r4_plo});

    // Stage 6: subtract OFF
    logic signed [FULL_W-1:0] full_sh;
    logic signed [Q_W-1:0]    n6_q, r6_q;
    logic signed [TEMP_W-1:0] r6_temp;
    assign full_sh = r5_full >>> 21;
    assign n6_q    = $signed({full_sh[QSH_W-1], full_sh[QSH_W-1:0]})
                   - $signed({{(Q_W-OFF_W){r5_off[OFF_W-1]}}, r5_off});

    // Stage 7: final shift and saturation
    logic signed [Q_W-1:0]    q_sh;
    logic signed [PSUM_W-1:0] p_w;
    logic signed [PRES_W-1:0] n7_p;
    assign q_sh = r6_q >>> 15;
    assign p_w  = q_sh[PSUM_W-1:0];

    always_comb begin
        if (p_w > PRES_MAX) begin
            n7_p = PRES_MAX[PRES_W-1:0];
        end else if (p_w < PRES_MIN) begin
            n7_p = PRES_MIN[PRES_W-1:0];
        end else begin
            n7_p = p_w[PRES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_dt   <= n1_dt;
            r1_d1   <= i_in_data.raw_pressure;

            r2_pt   <= r1_dt * $signed({1'b0, r_c6});
            r2_po   <= r1_dt * $signed({1'b0, r_c4});
            r2_ps   <= r1_dt * $signed({1'b0, r_c3});
            r2_d1   <= r1_d1;

            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_d1   <= r2_d1;

            r4_plo  <= r3_d1 * r3_sens[SLO_W-1:0];
            r4_phi  <= $signed({1'b0, r3_d1}) * $signed(r3_sens[SENS_W-1:SLO_W]);
            r4_off  <= r3_off;
            r4_temp <= r3_temp;

            r5_full <= n5_full;
            r5_off  <= r4_off;
            r5_temp <= r4_temp;

            r6_q    <= n6_q;
            r6_temp <= r5_temp;

            o_out_data.temp_centideg <= r6_temp;
            o_out_data.pressure_pa   <= n7_p;
        end
    end

endmodule

### rtl/bpc_checker.sv
`include "barometric_pressure_compensation_assert.svh"

module bpc_checker
    import bpc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input t_in_item           i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [ADDR_W-1:0]  paddr,
    input logic [DATA_W-1:0]  pwdata,
    input logic [DATA_W-1:0]  prdata,
    input logic               pready
);

    logic out_held;
    assign out_held = o_out_valid && i_out_stall;

    // A held output beat stays put
    `BPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out_data))
    // Input stalls only behind a held output beat
    `BPC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, out_held)
    // Reset empties the pipeline
    `BPC_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_out_valid)
    // Register port never waits
    `BPC_ASSERT_IMPL(a_pready, i_clk, i_rst_n, psel, pready)

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

### tb/sv/barometric_pressure_compensation_test.sv
`timescale 1ns / 1ps
module barometric_pressure_compensation_test
    import bpc_pkg::*;
;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int PIPE_SLACK       = 12;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PHASES    = 6;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int PAUSE_PHASE      = 3;
    localparam int PAUSE_AT         = 40;
    localparam int CAL_WORDS        = 6;

    localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [RAW_W-1:0]  RAW_MAX = {RAW_W{1'b1}};
    localparam logic [DATA_W-1:0] CAL_MAX = 32'h0000_FFFF;

    localparam longint TEMP_OFFSET = 2000;
    localparam longint TEMP_LO     = -262144;
    localparam longint TEMP_HI     = 262143;
    localparam longint PRES_LO     = -8388608;
    localparam longint PRES_HI     = 8388607;

    // typical factory words and readings of the sensor family
    localparam logic [DATA_W-1:0] TYP_C1 = 32'd46372;
    localparam logic [DATA_W-1:0] TYP_C2 = 32'd43981;
    localparam logic [DATA_W-1:0] TYP_C3 = 32'd29059;
    localparam logic [DATA_W-1:0] TYP_C4 = 32'd27842;
    localparam logic [DATA_W-1:0] TYP_C5 = 32'd31553;
    localparam logic [DATA_W-1:0] TYP_C6 = 32'd28165;
    localparam logic [RAW_W-1:0]  TYP_D1 = 24'd6465444;
    localparam logic [RAW_W-1:0]  TYP_D2 = 24'd8077636;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    barometric_pressure_compensation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    logic [CAL_W-1:0] cal_words [CAL_WORDS];
    t_out_item        expected_results [$];
    t_out_item        due_result;
    int               mismatches;
    int               cycles;
    int               burst_left;
    bit               gaps_on;
    int               stall_tick;
    int               stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure: switch between a few stall patterns now and then
    always @(negedge i_clk) begin
        stall_tick = stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_tick[2];
        endcase
    end

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic t_out_item predict_compensation(t_in_item rd);
        longint d1, d2, dt, temp, off, sens, pres;
        t_out_item res;
        d1   = longint'(rd.raw_pressure);
        d2   = longint'(rd.raw_temperature);
        dt   = d2 - longint'(cal_words[REG_REF_TEMP]) * (longint'(1) << 8);
        temp = TEMP_OFFSET + ((dt * longint'(cal_words[REG_SLOPE])) >>> 23);
        off  = longint'(cal_words[REG_OFFSET]) * (longint'(1) << 17)
             + ((longint'(cal_words[REG_OFF_TEMP]) * dt) >>> 6);
        sens = longint'(cal_words[REG_SENS]) * (longint'(1) << 16)
             + ((longint'(cal_words[REG_SENS_TEMP]) * dt) >>> 7);
        pres = (((d1 * sens) >>> 21) - off) >>> 15;
        temp = clamp_range(temp, TEMP_LO, TEMP_HI);
        pres = clamp_range(pres, PRES_LO, PRES_HI);
        res.temp_centideg = temp[TEMP_W-1:0];
        res.pressure_pa   = pres[PRES_W-1:0];
        return res;
    endfunction

    function automatic t_in_item make_reading(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
        t_in_item rd;
        rd.raw_pressure    = d1;
        rd.raw_temperature = d2;
        return rd;
    endfunction

    function automatic t_in_item random_reading();
        int near;
        int kind;
        t_in_item rd;
        kind = $urandom_range(0, 9);
        near = int'(cal_words[REG_REF_TEMP]) * 256 + int'($urandom_range(0, 8191)) - 4096;
        if (near < 0)
            near = 0;
        if (near > int'(RAW_MAX))
            near = int'(RAW_MAX);
        rd.raw_pressure    = RAW_W'($urandom);
        rd.raw_temperature = RAW_W'($urandom);
        case (kind)
            5, 6: begin
                rd.raw_pressure    = RAW_W'($urandom_range(4000000, 9000000));
                rd.raw_temperature = RAW_W'(near);
            end
            7: begin
                rd.raw_pressure    = $urandom_range(0, 1) ? RAW_MAX : '0;
                rd.raw_temperature = $urandom_range(0, 1) ? RAW_MAX : '0;
            end
            8: rd.raw_temperature = RAW_W'(near);
            9: begin
                rd.raw_pressure    = RAW_W'($urandom_range(4000000, 9000000));
                rd.raw_temperature = RAW_W'($urandom_range(6000000, 10000000));
            end
            default: ;
        endcase
        return rd;
    endfunction

    task automatic read_cal_word(input logic [2:0] idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[CAL_W-1:0] !== cal_words[idx]) begin
            $display("%0t readback reg %0d: expected %h, actual %h",
                     $time, idx, cal_words[idx], prdata[CAL_W-1:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_cal_word(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx < CAL_WORDS)
            cal_words[idx] = value[CAL_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < CAL_WORDS)
            read_cal_word(idx);
    endtask

    task automatic set_calibration(input logic [DATA_W-1:0] c1, input logic [DATA_W-1:0] c2,
                                   input logic [DATA_W-1:0] c3, input logic [DATA_W-1:0] c4,
                                   input logic [DATA_W-1:0] c5, input logic [DATA_W-1:0] c6);
        write_cal_word(REG_SENS, c1);
        write_cal_word(REG_OFFSET, c2);
        write_cal_word(REG_SENS_TEMP, c3);
        write_cal_word(REG_OFF_TEMP, c4);
        write_cal_word(REG_REF_TEMP, c5);
        write_cal_word(REG_SLOPE, c6);
    endtask

    task automatic send_reading(input t_in_item rd);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= rd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_results.push_back(predict_compensation(rd));
        if (gaps_on) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 6);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // drop valid and hold until the pipeline has handed back every beat
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual temp %0d pres %0d",
                         $time, o_out_data.temp_centideg, o_out_data.pressure_pa);
                mismatches++;
            end else begin
                due_result = expected_results.pop_front();
                if (o_out_data.temp_centideg !== due_result.temp_centideg) begin
                    $display("%0t temp_centideg: expected %0d, actual %0d", $time,
                             due_result.temp_centideg, o_out_data.temp_centideg);
                    mismatches++;
                end
                if (o_out_data.pressure_pa !== due_result.pressure_pa) begin
                    $display("%0t pressure_pa: expected %0d, actual %0d", $time,
                             due_result.pressure_pa, o_out_data.pressure_pa);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_reset_calibration();
        read_cal_word(REG_SENS);
        read_cal_word(REG_OFFSET);
        read_cal_word(REG_SENS_TEMP);
        read_cal_word(REG_OFF_TEMP);
        read_cal_word(REG_REF_TEMP);
        read_cal_word(REG_SLOPE);
        send_reading(make_reading(RAW_MAX, RAW_MAX));
        send_reading(make_reading(TYP_D1, TYP_D2));
        wait_results_drained();
    endtask

    task automatic test_corner_readings();
        set_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
        send_reading(make_reading('0, '0));
        send_reading(make_reading(RAW_MAX, RAW_MAX));
        send_reading(make_reading(RAW_MAX, '0));
        send_reading(make_reading('0, RAW_MAX));
        send_reading(make_reading(TYP_D1, TYP_D2));
        // zero dT: temperature exactly at the reference point
        send_reading(make_reading(TYP_D1, RAW_W'(TYP_C5 * 256)));
        wait_results_drained();
    endtask

    task automatic test_calibration_extremes();
        set_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
        send_reading(make_reading('0, '0));
        send_reading(make_reading(RAW_MAX, RAW_MAX));
        send_reading(make_reading(RAW_MAX, '0));
        send_reading(make_reading('0, RAW_MAX));
        wait_results_drained();
        // no base sensitivity and a large negative dT drive SENS, OFF and P negative
        set_calibration('0, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
        send_reading(make_reading(RAW_MAX, '0));
        send_reading(make_reading(TYP_D1, 24'd1));
        send_reading(make_reading(RAW_MAX, 24'd4096));
        wait_results_drained();
    endtask

    task automatic test_unmapped_and_wide_writes();
        set_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
        write_cal_word(REG_UNMAPPED_LO, $urandom);
        write_cal_word(REG_UNMAPPED_HI, $urandom);
        // upper data bits fall away
        write_cal_word(REG_SENS, 32'hFFFF_0000 | TYP_C1);
        write_cal_word(REG_SLOPE, 32'hA5A5_0000 | TYP_C6);
        send_reading(make_reading(TYP_D1, TYP_D2));
        send_reading(make_reading(RAW_MAX, RAW_MAX));
        wait_results_drained();
    endtask

    task automatic test_random_readings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_calibration('0, '0, '0, '0, '0, '0);
                1: set_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
                2: set_calibration(TYP_C1, TYP_C2, TYP_C3, TYP_C4, TYP_C5, TYP_C6);
                default: set_calibration($urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom);
            endcase
            gaps_on    = (phase != 2);
            burst_left = $urandom_range(1, 12);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_reading(random_reading());
                if (phase == PAUSE_PHASE && n == PAUSE_AT)
                    wait_results_drained();
            end
            wait_results_drained();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_stall = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        cycles     = 0;
        stall_tick = 0;
        stall_mode = 0;
        gaps_on    = 1'b1;
        burst_left = 4;
        for (int i = 0; i < CAL_WORDS; i++)
            cal_words[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_calibration();
        test_corner_readings();
        test_calibration_extremes();
        test_unmapped_and_wide_writes();
        test_random_readings();

        wait_results_drained();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
